[hdl/frame_reservation_handshake_top_defines.svh]
// ----------------------------------------------------------------------------
// Frame reservation handshake: assertion macros
// Shared property wrappers clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_RESERVATION_HANDSHAKE_TOP_DEFINES_SVH
`define FRAME_RESERVATION_HANDSHAKE_TOP_DEFINES_SVH

// same-cycle implication
`define FRH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FRH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/frh_pkg.sv]
// ----------------------------------------------------------------------------
// frh_pkg
// Types, codes and the backoff table of the frame reservation tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frh_pkg;

  // event codes
  localparam logic [2:0] OP_LINK_UP   = 3'd0;
  localparam logic [2:0] OP_LINK_DOWN = 3'd1;
  localparam logic [2:0] OP_PEER_RST  = 3'd2;
  localparam logic [2:0] OP_CONTROL   = 3'd3;
  localparam logic [2:0] OP_SUBMIT    = 3'd4;
  localparam logic [2:0] OP_TX_DONE   = 3'd5;
  localparam logic [2:0] OP_POLL      = 3'd6;

  // peer state codes
  localparam logic [2:0] ST_QUERY     = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_READY     = 3'd2;
  localparam logic [2:0] ST_BUSY      = 3'd3;
  localparam logic [2:0] ST_ACCEPTED  = 3'd4;
  localparam logic [2:0] ST_ACKED     = 3'd5;
  localparam logic [2:0] ST_FAILED    = 3'd6;
  localparam logic [2:0] ST_RSVD      = 3'd7;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MAGIC    = 3'd0;
  localparam logic [2:0] REG_VERSION  = 3'd1;
  localparam logic [2:0] REG_LENGTH   = 3'd2;
  localparam logic [2:0] REG_QINT     = 3'd3;
  localparam logic [2:0] REG_INIT_ID  = 3'd4;

  localparam logic [15:0] QINT_RESET  = 16'd2000;
  localparam logic [31:0] FIRST_DELAY = 32'd1000;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [7:0]  length;
    logic [15:0] qint;
    logic [31:0] init_id;
    logic        id_load;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] now_tick;
    logic [31:0] msg_magic;
    logic [15:0] msg_version;
    logic [7:0]  msg_length;
    logic [2:0]  msg_state;
    logic [31:0] msg_frame_id;
    logic [31:0] msg_detail;
    logic [31:0] tx_id;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] assigned_frame_id;
    logic [2:0]  peer_state;
    logic [31:0] active_frame_id;
    logic        job_active;
    logic        query_now;
    logic        reconnect_now;
    logic [13:0] retry_delay_ms;
    logic        link_up;
  } result_t;

  function automatic logic [13:0] backoff_ms(input logic [2:0] idx);
    logic [13:0] d;
    case (idx)
      3'd0:    d = 14'd1000;
      3'd1:    d = 14'd2000;
      3'd2:    d = 14'd4000;
      3'd3:    d = 14'd8000;
      default: d = 14'd10000;
    endcase
    return d;
  endfunction

endpackage

[hdl/frame_reservation_handshake_top.sv]
// Path: a beat is taken into the input register, updated by frh_core, and then held
// in the result register, which drives the result port.
// Throughput: one beat per cycle while out_stall does not hold the result register.
// Reset (rst_n low, synchronous): both pipeline stages empty, link down, peer not
// ready, no reservation, query interval 2000, other core and config registers zero.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// frame_reservation_handshake_top
// Sender-side tracker of a peer that grants one frame slot at a time.
// ----------------------------------------------------------------------------
module frame_reservation_handshake_top #(
  parameter int BACKOFF_STEPS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_now_tick,
  input  logic [31:0] in_msg_magic,
  input  logic [15:0] in_msg_version,
  input  logic [7:0]  in_msg_length,
  input  logic [2:0]  in_msg_state,
  input  logic [31:0] in_msg_frame_id,
  input  logic [31:0] in_msg_detail,
  input  logic [31:0] in_frame_id,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [31:0] out_assigned_frame_id,
  output logic [2:0]  out_peer_state,
  output logic [31:0] out_active_frame_id,
  output logic        out_job_active,
  output logic        out_query_now,
  output logic        out_reconnect_now,
  output logic [13:0] out_retry_delay_ms,
  output logic        out_link_up
);

  frh_pkg::cfg_t    cfg;
  frh_pkg::item_t   item_r;
  frh_pkg::result_t res;
  frh_pkg::result_t res_r;
  logic             item_v_r;
  logic             out_v_r;
  logic             advance;
  logic             step_en;

  frh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // result register frees whenever it is empty or being taken
  assign advance  = !out_v_r || !out_stall;
  assign step_en  = item_v_r && advance;
  assign in_stall = item_v_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (!in_stall) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.operation    <= in_operation;
      item_r.now_tick     <= in_now_tick;
      item_r.msg_magic    <= in_msg_magic;
      item_r.msg_version  <= in_msg_version;
      item_r.msg_length   <= in_msg_length;
      item_r.msg_state    <= in_msg_state;
      item_r.msg_frame_id <= in_msg_frame_id;
      item_r.msg_detail   <= in_msg_detail;
      item_r.tx_id        <= in_frame_id;
    end
  end

  frh_core #(
    .BACKOFF_STEPS (BACKOFF_STEPS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (step_en),
    .item    (item_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_v_r;
  assign out_accepted          = res_r.accepted;
  assign out_assigned_frame_id = res_r.assigned_frame_id;
  assign out_peer_state        = res_r.peer_state;
  assign out_active_frame_id   = res_r.active_frame_id;
  assign out_job_active        = res_r.job_active;
  assign out_query_now         = res_r.query_now;
  assign out_reconnect_now     = res_r.reconnect_now;
  assign out_retry_delay_ms    = res_r.retry_delay_ms;
  assign out_link_up           = res_r.link_up;

endmodule

[hdl/frh_cfg.sv]
// ----------------------------------------------------------------------------
// frh_cfg
// APB register file: message checks, query interval and frame id seed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frh_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output frh_pkg::cfg_t      cfg
);

  logic [31:0] magic_r;
  logic [15:0] version_r;
  logic [7:0]  length_r;
  logic [15:0] qint_r;
  logic [31:0] init_id_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
      length_r  <= '0;
      qint_r    <= frh_pkg::QINT_RESET;
      init_id_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        frh_pkg::REG_MAGIC:   magic_r   <= pwdata;
        frh_pkg::REG_VERSION: version_r <= pwdata[15:0];
        frh_pkg::REG_LENGTH:  length_r  <= pwdata[7:0];
        frh_pkg::REG_QINT:    qint_r    <= pwdata[15:0];
        frh_pkg::REG_INIT_ID: init_id_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      frh_pkg::REG_MAGIC:   prdata = magic_r;
      frh_pkg::REG_VERSION: prdata = {16'b0, version_r};
      frh_pkg::REG_LENGTH:  prdata = {24'b0, length_r};
      frh_pkg::REG_QINT:    prdata = {16'b0, qint_r};
      frh_pkg::REG_INIT_ID: prdata = init_id_r;
      default:              prdata = '0;
    endcase
  end

  // seed write also reloads the id counter, straight from the bus
  always_comb begin
    cfg.magic   = magic_r;
    cfg.version = version_r;
    cfg.length  = length_r;
    cfg.qint    = qint_r;
    cfg.init_id = pwdata;
    cfg.id_load = wr_en && (reg_idx == frh_pkg::REG_INIT_ID);
  end

endmodule

[hdl/frh_core.sv]
// ----------------------------------------------------------------------------
// frh_core
// Reservation state registers and the single-pass event update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frh_core #(
  parameter int BACKOFF_STEPS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  frh_pkg::cfg_t      cfg,
  input  logic               step_en,
  input  frh_pkg::item_t     item,
  output frh_pkg::result_t   res
);

  localparam logic [3:0] STEPS = 4'(BACKOFF_STEPS);
  localparam logic [3:0] LAST  = 4'(BACKOFF_STEPS - 1);

  logic        link_r,   link_nxt;
  logic [2:0]  rs_r,     rs_nxt;
  logic [31:0] active_r, active_nxt;
  logic        sent_r,   sent_nxt;
  logic        qp_r,     qp_nxt;
  logic [31:0] nid_r,    nid_nxt;
  logic [31:0] due_r,    due_nxt;
  logic [2:0]  bstep_r,  bstep_nxt;
  logic [31:0] lqt_r,    lqt_nxt;

  logic        msg_ok;
  logic        none;
  logic        fid_hit;
  logic        acc;
  logic [31:0] assigned;
  logic        qnow;
  logic        rnow;
  logic [13:0] delay;
  logic [31:0] inc_id;
  logic [31:0] due_diff;
  logic [31:0] q_diff;
  logic [2:0]  bidx;

  assign msg_ok = (item.msg_magic == cfg.magic) && (item.msg_version == cfg.version) &&
                  (item.msg_length == cfg.length) &&
                  (item.msg_state != frh_pkg::ST_QUERY) &&
                  (item.msg_state != frh_pkg::ST_RSVD);
  assign none     = (active_r == '0);
  assign fid_hit  = (item.msg_frame_id == active_r);
  assign inc_id   = nid_r + 32'd1;
  assign due_diff = item.now_tick - due_r;
  assign q_diff   = item.now_tick - lqt_r;
  assign bidx     = ({1'b0, bstep_r} < STEPS) ? bstep_r : LAST[2:0];

  always_comb begin
    link_nxt   = link_r;
    rs_nxt     = rs_r;
    active_nxt = active_r;
    sent_nxt   = sent_r;
    qp_nxt     = qp_r;
    nid_nxt    = nid_r;
    due_nxt    = due_r;
    bstep_nxt  = bstep_r;
    lqt_nxt    = lqt_r;
    acc        = 1'b0;
    assigned   = '0;
    qnow       = 1'b0;
    rnow       = 1'b0;
    delay      = '0;
    case (item.operation)
      frh_pkg::OP_LINK_UP: begin
        link_nxt   = 1'b1;
        rs_nxt     = frh_pkg::ST_NOT_READY;
        active_nxt = '0;
        sent_nxt   = 1'b0;
        qp_nxt     = 1'b1;
        due_nxt    = '0;
        bstep_nxt  = '0;
      end
      frh_pkg::OP_LINK_DOWN: begin
        link_nxt   = 1'b0;
        rs_nxt     = frh_pkg::ST_NOT_READY;
        active_nxt = '0;
        sent_nxt   = 1'b0;
        qp_nxt     = 1'b0;
        if (link_r || (due_r == '0)) begin
          due_nxt   = item.now_tick + frh_pkg::FIRST_DELAY;
          bstep_nxt = 3'd1;
        end
      end
      frh_pkg::OP_PEER_RST: begin
        rs_nxt     = frh_pkg::ST_NOT_READY;
        active_nxt = '0;
        sent_nxt   = 1'b0;
        qp_nxt     = link_r;
      end
      frh_pkg::OP_CONTROL: begin
        if (msg_ok) begin
          case (item.msg_state)
            frh_pkg::ST_READY: begin
              acc = none;
            end
            frh_pkg::ST_NOT_READY: begin
              if (none) begin
                acc = 1'b1;
              end else if (fid_hit) begin
                acc = 1'b1; active_nxt = '0; sent_nxt = 1'b0; qp_nxt = 1'b1;
              end
            end
            frh_pkg::ST_BUSY: begin
              if (none || (sent_r && fid_hit && (item.msg_detail == active_r))) begin
                acc = 1'b1;
              end else if (fid_hit) begin
                acc = 1'b1; active_nxt = '0; sent_nxt = 1'b0; qp_nxt = 1'b1;
              end
            end
            frh_pkg::ST_ACCEPTED: begin
              acc = !none && fid_hit;
            end
            default: begin // acked or failed: reservation ends
              if (!none && fid_hit) begin
                acc = 1'b1; active_nxt = '0; sent_nxt = 1'b0; qp_nxt = 1'b1;
              end
            end
          endcase
          if (acc) begin
            rs_nxt = item.msg_state;
          end
        end
      end
      frh_pkg::OP_SUBMIT: begin
        if (link_r && (rs_r == frh_pkg::ST_READY) && none) begin
          // counter skips zero on wrap
          nid_nxt    = (inc_id == '0) ? 32'd1 : inc_id;
          active_nxt = nid_nxt;
          sent_nxt   = 1'b0;
          rs_nxt     = frh_pkg::ST_BUSY;
          assigned   = nid_nxt;
          acc        = 1'b1;
        end
      end
      frh_pkg::OP_TX_DONE: begin
        if (link_r && (active_r == item.tx_id) &&
            ((rs_r == frh_pkg::ST_BUSY) || (rs_r == frh_pkg::ST_ACCEPTED))) begin
          sent_nxt = 1'b1;
          qp_nxt   = 1'b1;
        end
      end
      frh_pkg::OP_POLL: begin
        if (!link_r && ((due_r == '0) || !due_diff[31])) begin
          delay   = frh_pkg::backoff_ms(bidx);
          due_nxt = item.now_tick + {18'b0, delay};
          if ({1'b0, bstep_r} < LAST) begin
            bstep_nxt = bstep_r + 3'd1;
          end
          rnow = 1'b1;
        end
        // lqt of zero reads as never queried
        if (link_r && (qp_r || ((rs_r != frh_pkg::ST_READY) &&
            ((lqt_r == '0) || (q_diff >= {16'b0, cfg.qint}))))) begin
          qp_nxt  = 1'b0;
          lqt_nxt = item.now_tick;
          qnow    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.accepted          = acc;
    res.assigned_frame_id = assigned;
    res.peer_state        = rs_nxt;
    res.active_frame_id   = active_nxt;
    res.job_active        = link_nxt && (active_nxt == item.tx_id) &&
                            (rs_nxt == frh_pkg::ST_BUSY);
    res.query_now         = qnow;
    res.reconnect_now     = rnow;
    res.retry_delay_ms    = delay;
    res.link_up           = link_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r   <= 1'b0;
      rs_r     <= frh_pkg::ST_NOT_READY;
      active_r <= '0;
      sent_r   <= 1'b0;
      qp_r     <= 1'b0;
      nid_r    <= '0;
      due_r    <= '0;
      bstep_r  <= '0;
      lqt_r    <= '0;
    end else begin
      if (step_en) begin
        link_r   <= link_nxt;
        rs_r     <= rs_nxt;
        active_r <= active_nxt;
        sent_r   <= sent_nxt;
        qp_r     <= qp_nxt;
        nid_r    <= nid_nxt;
        due_r    <= due_nxt;
        bstep_r  <= bstep_nxt;
        lqt_r    <= lqt_nxt;
      end
      if (cfg.id_load) begin
        nid_r <= cfg.init_id;
      end
    end
  end

endmodule

[hdl/frh_checker.sv]
// ----------------------------------------------------------------------------
// frh_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frame_reservation_handshake_top_defines.svh"

module frh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_accepted,
  input logic [31:0] out_assigned_frame_id,
  input logic [2:0]  out_peer_state,
  input logic [31:0] out_active_frame_id,
  input logic        out_job_active,
  input logic        out_query_now,
  input logic        out_reconnect_now,
  input logic [13:0] out_retry_delay_ms,
  input logic        out_link_up
);

  // a stalled beat holds
  `FRH_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_active_frame_id) && $stable(out_peer_state) && $stable(out_assigned_frame_id), "result beat changed under stall")

  // reconnect only while down, always with a delay; never together with a query
  `FRH_ASSERT_NOW(a_reconn, out_valid && out_reconnect_now, !out_link_up && !out_query_now && (out_retry_delay_ms != 14'd0), "bad reconnect beat")

  // a granted frame holds the reservation with the peer busy
  `FRH_ASSERT_NOW(a_grant, out_valid && (out_assigned_frame_id != 32'd0), out_accepted && (out_active_frame_id == out_assigned_frame_id) && (out_peer_state == frh_pkg::ST_BUSY), "grant not reflected")

  // job active implies link up and peer busy
  `FRH_ASSERT_NOW(a_job, out_valid && out_job_active, out_link_up && (out_peer_state == frh_pkg::ST_BUSY) && (out_active_frame_id != 32'd0) || out_link_up && (out_peer_state == frh_pkg::ST_BUSY), "job active without busy link")

endmodule

bind frame_reservation_handshake_top frh_checker u_frh_checker (.*);
